>>> hdl/ffq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffq_pkg
// Shared types and constants of the frame handle queue.
// ----------------------------------------------------------------------------
package ffq_pkg;

  localparam int CNT_W      = 5;
  localparam int REQ_W      = 8;
  localparam int OP_W       = 3;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_CNT   = 3'd2,
    OP_FLUSH = 3'd3,
    OP_IND   = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ELEM         = 3'd0,
    KIND_COUNT        = 3'd1,
    KIND_NONE         = 3'd2,
    KIND_EMPTY_REPLY  = 3'd3,
    KIND_NOT_FULL     = 3'd4,
    KIND_EMPTY_NOTICE = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY   = 2'd0,
    CFG_AUTO_FIRST = 2'd1,
    CFG_DEFER      = 2'd2,
    CFG_AUTO_FULL  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             full;
    logic             near_full;
    logic             empty;
    logic [CNT_W-1:0] fill;
    logic             auto_first_en;
    logic             defer_en;
    logic             auto_full_en;
    logic             first_pending;
    logic             deferred;
    logic             announce;
  } st_t;

  typedef struct packed {
    logic             load;
    logic             push;
    logic             pop;
    logic             emit;
    logic             last;
    logic             set_defer;
    logic             clr_defer;
    logic             clr_first;
    logic             clr_announce;
    kind_e            kind;
    logic [CNT_W-1:0] burst;
  } cmd_t;

endpackage

>>> hdl/ffq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ffq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffq_dpath
// Queue storage, pointers, fill level, flags and configuration registers.
// ----------------------------------------------------------------------------
module ffq_dpath
  import ffq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ELEM_WIDTH-1:0] element_i,
  input  cmd_t                  cmd_i,
  output st_t                   st_o,
  output logic                  valid_o,
  output logic [KIND_W-1:0]     kind_o,
  output logic [ELEM_WIDTH-1:0] element_out_o,
  output logic [CNT_W-1:0]      burst_count_o,
  output logic                  last_o
);

  localparam int PW     = $clog2(DEPTH);
  localparam int CapLim = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CapLim);
  localparam logic [PW-1:0]    PTR_MAX = PW'(DEPTH - 1);

  logic [PW-1:0]         head_q, head_d, tail_q, tail_d, head_inc, tail_inc, raddr;
  logic [CNT_W-1:0]      fill_q, fill_d, cap_q, cap_eff;
  logic                  first_q, defer_q, announce_q;
  logic                  afe_q, dfe_q, afu_q;
  logic [ELEM_WIDTH-1:0] elem_q, rdata;
  logic [CNT_W:0]        fill_inc;

  assign head_inc = (head_q == PTR_MAX) ? '0 : head_q + PW'(1);
  assign tail_inc = (tail_q == PTR_MAX) ? '0 : tail_q + PW'(1);
  assign raddr    = cmd_i.pop ? head_inc : head_q;

  ffq_ram #(
    .WIDTH(ELEM_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(tail_q),
    .wdata_i(elem_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (cmd_i.push) begin
      tail_d = tail_inc;
      fill_d = fill_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      head_d = head_inc;
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      first_q    <= 1'b1;
      defer_q    <= 1'b0;
      announce_q <= 1'b1;
      cap_q      <= CAP_RESET;
      afe_q      <= 1'b0;
      dfe_q      <= 1'b0;
      afu_q      <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      if (cmd_i.clr_first) begin
        first_q <= 1'b0;
      end
      if (cmd_i.set_defer) begin
        defer_q <= 1'b1;
      end else if (cmd_i.clr_defer) begin
        defer_q <= 1'b0;
      end
      if (cmd_i.clr_announce) begin
        announce_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY:   cap_q <= cfg_data_i;
          CFG_AUTO_FIRST: afe_q <= cfg_data_i[0];
          CFG_DEFER:      dfe_q <= cfg_data_i[0];
          CFG_AUTO_FULL:  afu_q <= cfg_data_i[0];
          default:        cap_q <= cap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      elem_q <= element_i;
    end
  end

  assign cap_eff  = (cap_q > CAP_LIM) ? CAP_LIM : cap_q;
  assign fill_inc = (CNT_W+1)'(fill_q) + (CNT_W+1)'(1);

  assign st_o.full          = (fill_q >= cap_eff);
  assign st_o.near_full     = (fill_inc >= (CNT_W+1)'(cap_eff));
  assign st_o.empty         = (fill_q == '0);
  assign st_o.fill          = fill_q;
  assign st_o.auto_first_en = afe_q;
  assign st_o.defer_en      = dfe_q;
  assign st_o.auto_full_en  = afu_q;
  assign st_o.first_pending = first_q;
  assign st_o.deferred      = defer_q;
  assign st_o.announce      = announce_q;

  assign valid_o       = cmd_i.emit;
  assign kind_o        = cmd_i.emit ? cmd_i.kind : '0;
  assign element_out_o = (cmd_i.emit && cmd_i.kind == KIND_ELEM) ? rdata : '0;
  assign burst_count_o = (cmd_i.emit && cmd_i.kind == KIND_COUNT) ? cmd_i.burst : '0;
  assign last_o        = cmd_i.emit & cmd_i.last;

endmodule

>>> hdl/ffq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffq_ctrl
// Operation sequencer: decodes an item and steps out its results.
// ----------------------------------------------------------------------------
module ffq_ctrl
  import ffq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [REQ_W-1:0] request_count_i,
  input  logic             trigger_flag_i,
  input  st_t              st_i,
  output cmd_t             cmd_o,
  output logic             busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SETTLE,
    S_ENQ_R1,
    S_POP_LAST,
    S_BURST,
    S_CODE
  } state_e;

  state_e           state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic             trig_q, trig_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, burst_q, burst_d;
  kind_e            kind_q, kind_d;
  logic             r1_pop_q, r1_pop_d, have_r1_q, have_r1_d, r2_q, r2_d;
  logic             flush_q, flush_d;
  cmd_t             cmd;

  always_comb begin
    logic             first_hit;
    logic             extra;
    logic [CNT_W-1:0] k;
    first_hit = st_i.first_pending && st_i.auto_first_en;
    extra     = first_hit || st_i.deferred;
    k         = (REQ_W'(st_i.fill) < req_q) ? st_i.fill : req_q[CNT_W-1:0];
    cmd       = '0;
    cmd.kind  = KIND_ELEM;
    state_d   = state_q;
    op_d      = op_q;
    req_d     = req_q;
    trig_d    = trig_q;
    cnt_d     = cnt_q;
    burst_d   = burst_q;
    kind_d    = kind_q;
    r1_pop_d  = r1_pop_q;
    have_r1_d = have_r1_q;
    r2_d      = r2_q;
    flush_d   = flush_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          op_d     = operation_i;
          req_d    = request_count_i;
          trig_d   = trigger_flag_i;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (op_q)
          OP_ENQ: begin
            if (!st_i.full) begin
              cmd.push  = 1'b1;
              r1_pop_d  = st_i.near_full && st_i.auto_full_en;
              have_r1_d = !st_i.near_full || r1_pop_d;
              r2_d      = extra && (!r1_pop_d || !st_i.empty);
              if (extra) begin
                if (first_hit) begin
                  cmd.clr_first = 1'b1;
                end else begin
                  cmd.clr_defer = 1'b1;
                end
              end
              if (have_r1_d || r2_d) begin
                state_d = S_SETTLE;
              end
            end
          end
          OP_DEQ: begin
            if (!st_i.empty) begin
              state_d = S_POP_LAST;
            end else begin
              cmd.set_defer = st_i.defer_en;
              kind_d        = KIND_EMPTY_NOTICE;
              state_d       = S_CODE;
            end
          end
          OP_CNT: begin
            if (st_i.empty) begin
              kind_d  = KIND_EMPTY_REPLY;
              state_d = S_CODE;
            end else if (req_q == '0) begin
              kind_d  = KIND_NONE;
              state_d = S_CODE;
            end else begin
              cnt_d   = k;
              burst_d = k;
              kind_d  = KIND_COUNT;
              flush_d = 1'b0;
              state_d = S_BURST;
            end
          end
          OP_FLUSH: begin
            if (!st_i.empty) begin
              cnt_d   = st_i.fill;
              flush_d = 1'b1;
              state_d = S_BURST;
            end
          end
          OP_IND: begin
            if (st_i.announce || trig_q) begin
              cmd.clr_announce = st_i.announce;
              kind_d           = KIND_NOT_FULL;
              state_d          = S_CODE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SETTLE: begin
        state_d = have_r1_q ? S_ENQ_R1 : S_POP_LAST;
      end
      S_ENQ_R1: begin
        cmd.emit = 1'b1;
        cmd.pop  = r1_pop_q;
        cmd.kind = r1_pop_q ? KIND_ELEM : KIND_NOT_FULL;
        cmd.last = !r2_q;
        state_d  = r2_q ? S_POP_LAST : S_IDLE;
      end
      S_POP_LAST: begin
        cmd.emit = 1'b1;
        cmd.pop  = 1'b1;
        cmd.last = 1'b1;
        state_d  = S_IDLE;
      end
      S_BURST: begin
        cmd.emit = 1'b1;
        cmd.pop  = 1'b1;
        cmd.last = flush_q && (cnt_q == CNT_W'(1));
        if (cnt_q == CNT_W'(1)) begin
          state_d = flush_q ? S_IDLE : S_CODE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_CODE: begin
        cmd.emit  = 1'b1;
        cmd.kind  = kind_q;
        cmd.last  = 1'b1;
        cmd.burst = burst_q;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= '0;
      req_q     <= '0;
      trig_q    <= 1'b0;
      cnt_q     <= '0;
      burst_q   <= '0;
      kind_q    <= KIND_ELEM;
      r1_pop_q  <= 1'b0;
      have_r1_q <= 1'b0;
      r2_q      <= 1'b0;
      flush_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      req_q     <= req_d;
      trig_q    <= trig_d;
      cnt_q     <= cnt_d;
      burst_q   <= burst_d;
      kind_q    <= kind_d;
      r1_pop_q  <= r1_pop_d;
      have_r1_q <= have_r1_d;
      r2_q      <= r2_d;
      flush_q   <= flush_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hdl/frame_fifo_with_auto_dequeue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_fifo_with_auto_dequeue
// An accepted item is first decoded; an enqueue with results then passes a
// settle state (RAM write then registered read). Results follow one per cycle,
// bursts and flushes pop one element per cycle. An item holds the block through
// its decode state, the settle state on an enqueue with results, and its results;
// the next item is taken the cycle after. Reset empties the queue; results
// cannot stall.
// ----------------------------------------------------------------------------
module frame_fifo_with_auto_dequeue
  import ffq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [ELEM_WIDTH-1:0] element_i,
  input  logic [REQ_W-1:0]      request_count_i,
  input  logic                  trigger_flag_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  valid_o,
  output logic [KIND_W-1:0]     kind_o,
  output logic [ELEM_WIDTH-1:0] element_out_o,
  output logic [CNT_W-1:0]      burst_count_o,
  output logic                  last_o
);

  st_t  st;
  cmd_t cmd;

  ffq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .operation_i    (operation_i),
    .request_count_i(request_count_i),
    .trigger_flag_i (trigger_flag_i),
    .st_i           (st),
    .cmd_o          (cmd),
    .busy_o         (busy)
  );

  ffq_dpath #(
    .DEPTH     (DEPTH),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .element_i    (element_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .valid_o      (valid_o),
    .kind_o       (kind_o),
    .element_out_o(element_out_o),
    .burst_count_o(burst_count_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside an item");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !valid_o)) else $error("decode cycle missing");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> (!valid_o && !busy)) else $error("result after last");

  a_single_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == KIND_EMPTY_NOTICE) |-> last_o)
    else $error("empty notice not final");
`endif

endmodule
